>>> rtl/core/dvse_pkg.sv
`timescale 1ns / 1ps

package dvse_pkg;

	// Bits of magnitude carried by the first byte and by each later byte
	localparam int unsigned FIRST_MAG_BITS = 6;
	localparam int unsigned NEXT_MAG_BITS  = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} dvse_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // take the request's sample, form the difference
		logic conv;   // form sign and magnitude
		logic emit;   // load the next byte into the output register
	} dvse_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;   // byte about to be emitted ends the sample
	} dvse_sts_t;

endpackage

>>> rtl/core/dvse_ctrl.sv
`timescale 1ns / 1ps

module dvse_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output dvse_pkg::dvse_cmd_t cmd,
	input  dvse_pkg::dvse_sts_t sts
);

	dvse_pkg::dvse_state_t state_q, state_d;
	logic                  out_valid_q, out_valid_d;
	logic                  slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dvse_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_stall    = 1'b1;
		out_valid_d = out_valid_q && out_stall;
		unique case (state_q)
			dvse_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = dvse_pkg::ST_CONV;
				end
			end
			dvse_pkg::ST_CONV: begin
				cmd.conv = 1'b1;
				state_d  = dvse_pkg::ST_EMIT;
			end
			dvse_pkg::ST_EMIT: begin
				if (slot_free) begin
					cmd.emit    = 1'b1;
					out_valid_d = 1'b1;
					if (sts.last) begin
						state_d = dvse_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = dvse_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/dvse_dp.sv
`timescale 1ns / 1ps

module dvse_dp #(
	parameter int unsigned SAMPLE_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         sample,
	input  logic                first_sample,
	input  dvse_pkg::dvse_cmd_t cmd,
	output dvse_pkg::dvse_sts_t sts,
	output logic [7:0]          code_byte,
	output logic                last_of_sample,
	output logic                clipped_error
);

	localparam logic [SAMPLE_WIDTH-1:0] TOP_BIT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	logic [SAMPLE_WIDTH-1:0] prev_q;
	logic [SAMPLE_WIDTH-1:0] diff_q;
	logic [SAMPLE_WIDTH-1:0] mag_q;
	logic                    sign_q;
	logic                    clip_q;
	logic                    first_q;
	logic [7:0]              byte_q;
	logic                    last_q;
	logic                    err_q;

	logic [SAMPLE_WIDTH-1:0] cur;
	logic [SAMPLE_WIDTH-1:0] rest_first;
	logic [SAMPLE_WIDTH-1:0] rest_next;
	logic [SAMPLE_WIDTH-1:0] rest;
	logic                    more;
	logic [7:0]              byte_d;

	assign cur = sample[SAMPLE_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (cmd.load) begin
			prev_q <= cur;
		end
	end

	assign rest_first = mag_q >> dvse_pkg::FIRST_MAG_BITS;
	assign rest_next  = mag_q >> dvse_pkg::NEXT_MAG_BITS;
	assign rest       = first_q ? rest_first : rest_next;
	assign more       = !clip_q && (rest != '0);

	always_comb begin
		if (clip_q) begin
			byte_d = 8'h00;
		end else if (first_q) begin
			byte_d = {more, mag_q[5:0], sign_q};
		end else begin
			byte_d = {more, mag_q[6:0]};
		end
	end

	assign sts.last = !more;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			// wraps to the sample width
			diff_q <= first_sample ? cur : cur - prev_q;
		end
		if (cmd.conv) begin
			sign_q  <= diff_q[SAMPLE_WIDTH-1];
			mag_q   <= diff_q[SAMPLE_WIDTH-1] ? (~diff_q + SAMPLE_WIDTH'(1)) : diff_q;
			clip_q  <= (diff_q == TOP_BIT);
			first_q <= 1'b1;
		end
		if (cmd.emit) begin
			byte_q  <= byte_d;
			last_q  <= !more;
			err_q   <= clip_q;
			mag_q   <= rest;
			first_q <= 1'b0;
		end
	end

	assign code_byte      = byte_q;
	assign last_of_sample = last_q;
	assign clipped_error  = err_q;

endmodule

>>> rtl/core/delta_varint_sample_encoder_top.sv
`timescale 1ns / 1ps

// Delta varint sample encoder. Each request carries one signed sample; the block
// codes its difference from the previous sample (zero when first_sample is set)
// as 1 to 5 bytes, sign in bit 0 of the first byte, bit 7 set while more bytes
// follow. A difference equal to the most negative value gives a single result with
// clipped_error set and code_byte zero. Each item first forms the difference, then
// sign and magnitude, then sends one byte per cycle through the output register
// while the output is not stalled. The next request is taken as soon as the last
// byte sits in the output register.
module delta_varint_sample_encoder_top #(
	parameter int unsigned SAMPLE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] sample,
	input  logic        first_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  code_byte,
	output logic        last_of_sample,
	output logic        clipped_error
);

	dvse_pkg::dvse_cmd_t cmd;
	dvse_pkg::dvse_sts_t sts;

	dvse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	dvse_dp #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample         (sample),
		.first_sample   (first_sample),
		.cmd            (cmd),
		.sts            (sts),
		.code_byte      (code_byte),
		.last_of_sample (last_of_sample),
		.clipped_error  (clipped_error)
	);

endmodule
